// ===== hdl/pbca_pkg.sv =====
// Shared types, mode codes and default sizes of the pseudo-Boolean constraint accumulator.
package pbca_pkg;

  localparam int NUM_VARIABLES_DEF = 1024;
  localparam int COEFF_BITS_DEF    = 32;

  localparam logic [2:0] MODE_LOAD       = 3'd0;
  localparam logic [2:0] MODE_ADD        = 3'd1;
  localparam logic [2:0] MODE_SET_DEG    = 3'd2;
  localparam logic [2:0] MODE_ADD_DEG    = 3'd3;
  localparam logic [2:0] MODE_UNLOAD     = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic [9:0]         variable;
    logic               negated;
    logic signed [31:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         out_variable;
    logic [30:0]        out_magnitude;
    logic               out_negated;
    logic               keep;
    logic               last;
    logic signed [31:0] degree_now;
    logic [10:0]        nonzero_count;
    logic               overflow;
  } out_word_t;

endpackage

// ===== hdl/pb_constraint_accumulator_top.sv =====
// Top level of the pseudo-Boolean constraint accumulator: sequencer around two RAMs.
// Degree, unused-mode, ignored-term and empty-unload words are answered from the accept
// cycle, a load or a term that a full used list drops from the coefficient RAM read, an
// add term after the add, magnitude and cancellation steps of the read-modify-write, and
// an unload after the order RAM read, then the coefficient RAM read. One word is in
// flight at a time; busy drops in the strobe cycle, so a new word can follow in that cycle.
// The receiver cannot stall. Synchronous reset starts a clearing pass over all NUM_VARIABLES entries.
module pb_constraint_accumulator_top
  import pbca_pkg::*;
#(
  parameter int NUM_VARIABLES = NUM_VARIABLES_DEF,
  parameter int COEFF_BITS    = COEFF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  request,
  output logic      done,
  output out_word_t result
);

  localparam int VAR_W = $clog2(NUM_VARIABLES);
  localparam int CNT_W = $clog2(NUM_VARIABLES + 1);
  localparam int DW    = COEFF_BITS + 1;
  localparam logic [CNT_W-1:0]      NUM_CNT   = CNT_W'(NUM_VARIABLES);
  localparam logic [VAR_W-1:0]      LAST_ADDR = VAR_W'(NUM_VARIABLES - 1);
  localparam logic [COEFF_BITS-1:0] SIGN_BIT  = {1'b1, {(COEFF_BITS-1){1'b0}}};

  // The coefficient RAM holds {used mark, signed coefficient} per variable. The order RAM
  // holds the variables in the order they were first touched.
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_TERM_A, S_TERM_B, S_TERM_C, S_TERM_D, S_UNL_A, S_UNL_B
  } state_t;

  state_t                        state;
  logic [VAR_W-1:0]              clr_addr;
  in_word_t                      req;
  logic signed [COEFF_BITS-1:0]  term_b;
  logic                          ovf_acc;
  logic signed [COEFF_BITS-1:0]  coef_c;
  logic [COEFF_BITS-1:0]         mag_a;
  logic [COEFF_BITS-1:0]         mag_b;
  logic [COEFF_BITS-1:0]         mag_x;
  logic [COEFF_BITS-1:0]         mag_c;
  logic [COEFF_BITS-1:0]         cancel;
  logic [VAR_W-1:0]              unl_var;
  logic [CNT_W-1:0]              used_total;
  logic [CNT_W-1:0]              unload_pointer;
  logic signed [COEFF_BITS-1:0]  degree_value;
  logic [CNT_W-1:0]              nonzero_total;

  logic             data_we;
  logic [VAR_W-1:0] data_waddr;
  logic [DW-1:0]    data_wdata;
  logic [VAR_W-1:0] data_raddr;
  logic [DW-1:0]    data_rdata;
  logic             ord_we;
  logic [VAR_W-1:0] ord_waddr;
  logic [VAR_W-1:0] ord_wdata;
  logic [VAR_W-1:0] ord_raddr;
  logic [VAR_W-1:0] ord_rdata;

  logic                         accept;
  logic                         in_range;
  logic signed [32:0]           amt_ext;
  logic signed [32:0]           amt_mag;
  logic signed [65:0]           b_full;
  logic signed [COEFF_BITS-1:0] b_trunc;
  logic                         b_ovf;
  logic signed [COEFF_BITS-1:0] amt_tr;
  logic                         amt_ovf;
  logic signed [COEFF_BITS-1:0] deg_sum;
  logic                         deg_sum_ovf;
  logic                         list_pending;
  logic                         rd_mark;
  logic signed [COEFF_BITS-1:0] rd_coef;
  logic                         touch_ok;
  logic                         load_do;
  logic [CNT_W-1:0]             nz_load;
  logic signed [COEFF_BITS-1:0] term_sum;
  logic                         sum_ovf;
  logic [CNT_W-1:0]             nz_add;
  logic signed [COEFF_BITS-1:0] deg_less;
  logic                         cancel_ovf;
  logic [COEFF_BITS-1:0]        unl_mag;
  logic [CNT_W-1:0]             nz_unl;
  logic [CNT_W-1:0]             ptr_inc;
  logic                         unl_last;
  logic                         res_fire;
  out_word_t                    res_word;
  out_word_t                    status_word;

  function automatic logic [COEFF_BITS-1:0] mag_of(input logic signed [COEFF_BITS-1:0] v);
    return v[COEFF_BITS-1] ? COEFF_BITS'(-v) : COEFF_BITS'(v);
  endfunction

  // Nonzero counter update when one entry goes from one value to another.
  function automatic logic [CNT_W-1:0] count_next(input logic [CNT_W-1:0] cur,
                                                  input logic was_nz, input logic now_nz);
    if (!was_nz && now_nz) begin
      return cur + CNT_W'(1);
    end else if (was_nz && !now_nz && cur != '0) begin
      return cur - CNT_W'(1);
    end
    return cur;
  endfunction

  pbca_ram #(.WIDTH(DW), .DEPTH(NUM_VARIABLES)) u_coef_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  pbca_ram #(.WIDTH(VAR_W), .DEPTH(NUM_VARIABLES)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Input decoding for the accept cycle: the signed term value and the degree operand.
  always_comb begin
    in_range    = 32'(request.variable) < NUM_VARIABLES;
    amt_ext     = 33'($signed(request.amount));
    amt_mag     = amt_ext[32] ? -amt_ext : amt_ext;
    b_full      = request.negated ? -66'(amt_mag) : 66'(amt_mag);
    b_trunc     = $signed(b_full[COEFF_BITS-1:0]);
    b_ovf       = 66'(b_trunc) != b_full;
    amt_tr      = COEFF_BITS'($signed(request.amount));
    amt_ovf     = 64'(amt_tr) != 64'($signed(request.amount));
    deg_sum     = degree_value + amt_tr;
    deg_sum_ovf = (degree_value[COEFF_BITS-1] == amt_tr[COEFF_BITS-1]) &&
                  (deg_sum[COEFF_BITS-1] != degree_value[COEFF_BITS-1]);
    list_pending = unload_pointer < used_total;
  end

  // Read-modify-write arithmetic on the coefficient that the RAM returns.
  always_comb begin
    rd_mark    = data_rdata[DW-1];
    rd_coef    = $signed(data_rdata[COEFF_BITS-1:0]);
    touch_ok   = rd_mark || (used_total < NUM_CNT);
    load_do    = (term_b != '0) && touch_ok;
    nz_load    = count_next(nonzero_total, rd_coef != '0, term_b != '0);
    term_sum   = rd_coef + term_b;
    sum_ovf    = (rd_coef[COEFF_BITS-1] == term_b[COEFF_BITS-1]) &&
                 (term_sum[COEFF_BITS-1] != rd_coef[COEFF_BITS-1]);
    nz_add     = count_next(nonzero_total, rd_coef != '0, term_sum != '0);
    deg_less   = degree_value - $signed(cancel);
    cancel_ovf = cancel > (COEFF_BITS'(degree_value) ^ SIGN_BIT);
    unl_mag    = mag_of(rd_coef);
    nz_unl     = count_next(nonzero_total, rd_coef != '0, 1'b0);
    ptr_inc    = unload_pointer + CNT_W'(1);
    unl_last   = ptr_inc >= used_total;
  end

  // RAM port steering. Only one state touches each RAM in a given cycle, and every
  // write lands before the next word is accepted, so no forwarding path is needed.
  always_comb begin
    data_raddr = (state == S_UNL_A) ? ord_rdata : VAR_W'(request.variable);
    ord_raddr  = unload_pointer[VAR_W-1:0];
    data_we    = 1'b0;
    data_waddr = req.variable[VAR_W-1:0];
    data_wdata = '0;
    ord_we     = 1'b0;
    ord_waddr  = used_total[VAR_W-1:0];
    ord_wdata  = VAR_W'(req.variable);
    unique case (state)
      S_CLEAR: begin
        data_we    = 1'b1;
        data_waddr = clr_addr;
      end
      S_TERM_A: begin
        data_waddr = VAR_W'(req.variable);
        if (req.mode == MODE_LOAD) begin
          data_we    = load_do;
          data_wdata = {1'b1, term_b};
          ord_we     = load_do && !rd_mark;
        end else begin
          data_we    = touch_ok;
          data_wdata = {1'b1, term_sum};
          ord_we     = touch_ok && !rd_mark;
        end
      end
      S_UNL_B: begin
        data_we    = 1'b1;
        data_waddr = unl_var;
      end
      default: begin
      end
    endcase
  end

  // Result word for the cycle in which an item finishes.
  always_comb begin
    status_word = '{
      out_variable:  '0,
      out_magnitude: '0,
      out_negated:   1'b0,
      keep:          1'b0,
      last:          1'b0,
      degree_now:    32'(degree_value),
      nonzero_count: 11'(nonzero_total),
      overflow:      1'b0
    };
    res_word = status_word;
    res_fire = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_fire = 1'b1;
          case (request.mode) inside
            MODE_LOAD, MODE_ADD: begin
              res_fire          = !in_range;
              res_word.overflow = b_ovf;
            end
            MODE_SET_DEG: begin
              res_word.degree_now = 32'(amt_tr);
              res_word.overflow   = amt_ovf;
            end
            MODE_ADD_DEG: begin
              res_word.degree_now = 32'(deg_sum);
              res_word.overflow   = amt_ovf || deg_sum_ovf;
            end
            MODE_UNLOAD: begin
              res_fire      = !list_pending;
              res_word.last = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_TERM_A: begin
        res_word.overflow = ovf_acc;
        if (req.mode == MODE_LOAD) begin
          res_fire = 1'b1;
          if (load_do) begin
            res_word.nonzero_count = 11'(nz_load);
          end
        end else begin
          res_fire = !touch_ok;
        end
      end
      S_TERM_D: begin
        res_fire            = 1'b1;
        res_word.degree_now = 32'(deg_less);
        res_word.overflow   = ovf_acc || cancel_ovf;
      end
      S_UNL_B: begin
        res_fire               = 1'b1;
        res_word.out_variable  = 10'(unl_var);
        res_word.out_magnitude = 31'(unl_mag);
        res_word.out_negated   = rd_coef[COEFF_BITS-1];
        res_word.keep          = rd_coef != '0;
        res_word.last          = unl_last;
        res_word.nonzero_count = 11'(nz_unl);
        res_word.overflow      = 64'(unl_mag) > 64'h7FFF_FFFF;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      used_total     <= '0;
      unload_pointer <= '0;
      degree_value   <= '0;
      nonzero_total  <= '0;
      done           <= 1'b0;
    end else begin
      done <= res_fire;
      if (res_fire) begin
        result <= res_word;
      end
      unique case (state)
        S_CLEAR: begin
          // Zero every coefficient and used mark, one entry per cycle.
          clr_addr <= clr_addr + VAR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req     <= request;
            term_b  <= b_trunc;
            ovf_acc <= b_ovf;
            case (request.mode) inside
              MODE_LOAD, MODE_ADD: begin
                if (in_range) begin
                  state <= S_TERM_A;
                end
              end
              MODE_SET_DEG: degree_value <= amt_tr;
              MODE_ADD_DEG: degree_value <= deg_sum;
              MODE_UNLOAD: begin
                if (list_pending) begin
                  state <= S_UNL_A;
                end else begin
                  used_total     <= '0;
                  unload_pointer <= '0;
                  degree_value   <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_TERM_A: begin
          if (req.mode == MODE_LOAD) begin
            state <= S_IDLE;
            if (load_do) begin
              nonzero_total <= nz_load;
              if (!rd_mark) begin
                used_total <= used_total + CNT_W'(1);
              end
            end
          end else if (touch_ok) begin
            nonzero_total <= nz_add;
            if (!rd_mark) begin
              used_total <= used_total + CNT_W'(1);
            end
            coef_c  <= term_sum;
            ovf_acc <= ovf_acc || sum_ovf;
            mag_a   <= mag_of(rd_coef);
            mag_b   <= mag_of(term_b);
            state   <= S_TERM_B;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TERM_B: begin
          mag_x <= (mag_a > mag_b) ? mag_a : mag_b;
          mag_c <= mag_of(coef_c);
          state <= S_TERM_C;
        end
        S_TERM_C: begin
          // Cancellation: how far the larger operand magnitude exceeds the sum's.
          cancel <= (mag_x > mag_c) ? (mag_x - mag_c) : '0;
          state  <= S_TERM_D;
        end
        S_TERM_D: begin
          degree_value <= deg_less;
          state        <= S_IDLE;
        end
        S_UNL_A: begin
          unl_var <= ord_rdata;
          state   <= S_UNL_B;
        end
        S_UNL_B: begin
          nonzero_total <= nz_unl;
          if (unl_last) begin
            used_total     <= '0;
            unload_pointer <= '0;
            degree_value   <= '0;
          end else begin
            unload_pointer <= ptr_inc;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The unload pointer never passes the end of the used list.
  assert property (@(posedge clk) disable iff (rst) unload_pointer <= used_total)
    else $error("unload pointer beyond used list");

  // The nonzero count never exceeds the number of used entries or else NUM_VARIABLES.
  assert property (@(posedge clk) disable iff (rst) nonzero_total <= used_total ||
                   nonzero_total <= NUM_CNT)
    else $error("nonzero count out of range");

  // A last unload leaves the used list empty when its word is presented.
  assert property (@(posedge clk) disable iff (rst)
                   done && result.last |-> used_total == '0 && unload_pointer == '0)
    else $error("used list not emptied on last unload");

  // A degree write finishes in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
                   accept && (request.mode == MODE_SET_DEG || request.mode == MODE_ADD_DEG)
                   |=> done)
    else $error("degree word not answered");

endmodule

// ===== hdl/pbca_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module pbca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/pbca_status_checker.sv =====
// Checker that predicts and compares every status word of the constraint accumulator.
`timescale 1ns / 1ps
module pbca_status_checker
  import pbca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  request,
  input  logic      done,
  input  out_word_t result,
  output int        failures,
  output int        pending,
  output int        compared
);

  localparam int VARS = NUM_VARIABLES_DEF;

  // Own copy of the accumulator state.
  logic signed [31:0] coef_mem  [VARS];
  bit                 in_list   [VARS];
  logic [9:0]         first_use [VARS];
  int                 list_len;
  int                 pop_idx;
  logic signed [31:0] degree;
  int                 nonzero;

  out_word_t          status_fifo [$];
  out_word_t          want;
  int                 fail_total = 0;
  int                 compare_total = 0;

  function automatic longint mag_of(logic signed [31:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Appends a variable to the first-use list; fails when the list is full.
  function automatic bit enlist(logic [9:0] v);
    if (in_list[v]) return 1'b1;
    if (list_len >= VARS) return 1'b0;
    in_list[v] = 1'b1;
    first_use[list_len] = v;
    list_len++;
    return 1'b1;
  endfunction

  function automatic void track_nonzero(logic signed [31:0] was, logic signed [31:0] now);
    if (was == 0 && now != 0) nonzero++;
    else if (was != 0 && now == 0 && nonzero > 0) nonzero--;
  endfunction

  function automatic logic signed [31:0] sum_wrap(logic signed [31:0] x,
                                                  logic signed [31:0] y, inout bit ovf);
    longint s;
    s = longint'(x) + longint'(y);
    if (s > 64'sd2147483647 || s < -64'sd2147483648) ovf = 1'b1;
    return s[31:0];
  endfunction

  function automatic out_word_t accumulate_word(in_word_t w);
    out_word_t          o;
    bit                 ovf;
    logic signed [31:0] amt, b, a, c, coef;
    longint             m, term, ma, mb, mc, mx, cancel;
    logic [9:0]         idx;
    o   = '0;
    ovf = 1'b0;
    amt = w.amount;
    case (w.mode) inside
      MODE_LOAD, MODE_ADD: begin
        m    = (amt < 0) ? -longint'(amt) : longint'(amt);
        term = w.negated ? -m : m;
        // Only a positive term of magnitude 2^31 fails to fit.
        if (term > 64'sd2147483647) ovf = 1'b1;
        b = term[31:0];
        if (w.mode == MODE_LOAD) begin
          if (b != 0 && enlist(w.variable)) begin
            track_nonzero(coef_mem[w.variable], b);
            coef_mem[w.variable] = b;
          end
        end else if (enlist(w.variable)) begin
          a  = coef_mem[w.variable];
          c  = sum_wrap(a, b, ovf);
          ma = mag_of(a);
          mb = mag_of(b);
          mc = mag_of(c);
          mx = (ma > mb) ? ma : mb;
          cancel = (mx > mc) ? mx - mc : 0;
          if (longint'(degree) - cancel < -64'sd2147483648) ovf = 1'b1;
          degree = degree - cancel[31:0];
          track_nonzero(a, c);
          coef_mem[w.variable] = c;
        end
        o.degree_now = degree;
      end
      MODE_SET_DEG: begin
        degree = amt;
        o.degree_now = degree;
      end
      MODE_ADD_DEG: begin
        degree = sum_wrap(degree, amt, ovf);
        o.degree_now = degree;
      end
      MODE_UNLOAD: begin
        o.degree_now = degree;
        if (pop_idx < list_len) begin
          idx  = first_use[pop_idx];
          coef = coef_mem[idx];
          ma   = mag_of(coef);
          if (ma > 64'sd2147483647) ovf = 1'b1;
          o.out_variable  = idx;
          o.out_magnitude = ma[30:0];
          o.out_negated   = (coef < 0);
          o.keep          = (coef != 0);
          track_nonzero(coef, '0);
          coef_mem[idx] = '0;
          in_list[idx]  = 1'b0;
          pop_idx++;
          if (pop_idx >= list_len) o.last = 1'b1;
        end else begin
          o.last = 1'b1;
        end
        if (o.last) begin
          list_len = 0;
          pop_idx  = 0;
          degree   = '0;
        end
      end
      default: begin
        o.degree_now = degree;
      end
    endcase
    o.nonzero_count = nonzero[10:0];
    o.overflow      = ovf;
    return o;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] exp_v,
                                      logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t  %s: expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VARS; k++) begin
        coef_mem[k]  = '0;
        in_list[k]   = 1'b0;
        first_use[k] = '0;
      end
      list_len = 0;
      pop_idx  = 0;
      degree   = '0;
      nonzero  = 0;
      status_fifo.delete();
    end else begin
      // The result accepted here belongs to an earlier word, so compare first.
      if (done) begin
        if (status_fifo.size() == 0) begin
          $display("%0t  unexpected status word: expected none, got %p", $time, result);
          fail_total++;
        end else begin
          want = status_fifo.pop_front();
          check_field("out_variable", want.out_variable, result.out_variable);
          check_field("out_magnitude", want.out_magnitude, result.out_magnitude);
          check_field("out_negated", want.out_negated, result.out_negated);
          check_field("keep", want.keep, result.keep);
          check_field("last", want.last, result.last);
          check_field("degree_now", want.degree_now, result.degree_now);
          check_field("nonzero_count", want.nonzero_count, result.nonzero_count);
          check_field("overflow", want.overflow, result.overflow);
          compare_total++;
        end
      end
      if (start && !busy) status_fifo = {status_fifo, accumulate_word(request)};
    end
    failures <= fail_total;
    pending  <= status_fifo.size();
    compared <= compare_total;
  end

endmodule

// ===== dv/pb_constraint_accumulator_top_tb.sv =====
// Testbench top for the constraint accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module pb_constraint_accumulator_top_tb;
  import pbca_pkg::*;

  // The slowest legal quiet stretch is the clearing pass after reset over all entries,
  // followed by a full sender gap; this limit leaves ample margin over that.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS   = 700;
  localparam int VARS           = NUM_VARIABLES_DEF;

  // The package names only the five real modes; the lowest and highest spare codes are named here.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_word_t  request = '0;
  logic      busy;
  logic      done;
  out_word_t result;

  int failures;
  int pending;
  int compared;
  int quiet_cycles = 0;
  int mode_hits [8];
  int burst_left = 0;
  int words_sent = 0;

  always #5 clk = ~clk;

  pb_constraint_accumulator_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  pbca_status_checker status_check (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .failures (failures),
    .pending  (pending),
    .compared (compared)
  );

  // Watchdog: any accepted word on either side restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Tally of accepted words per mode, for the closing summary.
  always @(posedge clk) begin
    if (!rst && start && !busy) mode_hits[request.mode] <= mode_hits[request.mode] + 1;
  end

  function automatic in_word_t make_word(logic [2:0] mode, logic [9:0] variable,
                                         logic negated, logic signed [31:0] amount);
    in_word_t w;
    w.mode     = mode;
    w.variable = variable;
    w.negated  = negated;
    w.amount   = amount;
    return w;
  endfunction

  // Coefficient or degree value: mostly small or medium values so that terms on the same
  // variable cancel often, plus the extremes and fully random patterns.
  function automatic logic signed [31:0] pick_amount();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 40)) - 20;
      4: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = -32'sd1;
          3: v = 32'sd1;
          default: v = '0;
        endcase
      end
      5, 6: v = int'($urandom_range(0, 131072)) - 65536;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offers one word to the block. The sender first idles for a random gap,
  // except inside bursts where words follow back to back. Start stays high
  // across consecutive words when there is no gap, so it is never lowered and
  // raised in the same time step.
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy !== 1'b0);
    if (w.mode <= MODE_UNLOAD) words_sent++;
  endtask

  // Holds the sender off until every predicted status word has come back. The
  // first edge lets the checker count a word accepted at the current edge.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int         directed_words;
    int         pool_n, n_terms, n_pops, roll, spare_hits;
    logic [9:0] pool [12];
    logic [9:0] base;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. An unload on an empty list comes first, then the degree
    // wraps in both directions.
    send_word(make_word(MODE_UNLOAD, '0, 1'b0, '0));
    send_word(make_word(MODE_SET_DEG, '0, 1'b0, 32'sh7fff_ffff));
    send_word(make_word(MODE_ADD_DEG, '0, 1'b0, 32'sd1));
    send_word(make_word(MODE_ADD_DEG, '0, 1'b0, -32'sd1));
    send_word(make_word(MODE_SET_DEG, '0, 1'b0, -32'sd5));
    // A positive term of magnitude 2^31 does not fit and wraps to the minimum.
    send_word(make_word(MODE_LOAD, 10'd0, 1'b0, 32'sh8000_0000));
    send_word(make_word(MODE_LOAD, 10'd1023, 1'b1, 32'sd7));
    // A load of zero changes nothing and does not enter the used list.
    send_word(make_word(MODE_LOAD, 10'd5, 1'b1, '0));
    // Opposite terms cancel completely and lower the degree.
    send_word(make_word(MODE_ADD, 10'd1023, 1'b0, -32'sd7));
    // Coefficient sum wraps past the maximum.
    send_word(make_word(MODE_ADD, 10'd10, 1'b0, 32'sh7fff_ffff));
    send_word(make_word(MODE_ADD, 10'd10, 1'b0, 32'sd1));
    // An add of zero on a fresh variable leaves a zero entry in the list.
    send_word(make_word(MODE_ADD, 10'd3, 1'b1, '0));
    // Cancellation drives the degree below the most negative value.
    send_word(make_word(MODE_SET_DEG, '0, 1'b0, 32'sh8000_0000));
    send_word(make_word(MODE_LOAD, 10'd2, 1'b0, 32'sd100));
    send_word(make_word(MODE_ADD, 10'd2, 1'b1, 32'sd100));
    send_word(make_word(MODE_SPARE_LO, 10'd77, 1'b1, 32'sd12345));
    send_word(make_word(MODE_SPARE_HI, '1, 1'b0, -32'sd1));
    // Partial unload, including the entry whose magnitude is too wide, then a
    // new variable joins behind the unload pointer.
    send_word(make_word(MODE_UNLOAD, '0, 1'b0, '0));
    send_word(make_word(MODE_UNLOAD, '0, 1'b0, '0));
    send_word(make_word(MODE_LOAD, 10'd500, 1'b1, -32'sd9));
    repeat (4) send_word(make_word(MODE_UNLOAD, '0, 1'b0, '0));
    send_word(make_word(MODE_UNLOAD, '1, 1'b1, '1));
    drain();
    directed_words = words_sent;

    // Random part: each round builds one combination over a small pool of
    // variables, then unloads about as many entries as it touched. Rounds that
    // pop too few leave entries for the next one, and some terms land while an
    // unload is under way. Words with random modes and fields are mixed in.
    while (words_sent - directed_words < RANDOM_WORDS) begin
      pool_n = $urandom_range(1, 12);
      base   = 10'($urandom_range(0, VARS - 1));
      for (int p = 0; p < pool_n; p++) begin
        case ($urandom_range(0, 7))
          0: pool[p] = '0;
          1: pool[p] = '1;
          2, 3: pool[p] = 10'($urandom_range(0, VARS - 1));
          default: pool[p] = 10'(base + p);
        endcase
      end
      if ($urandom_range(0, 1)) send_word(make_word(MODE_SET_DEG, '0, 1'b0, pick_amount()));
      n_terms = $urandom_range(pool_n, 3 * pool_n);
      for (int t = 0; t < n_terms; t++) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          send_word(make_word(3'($urandom_range(0, 7)), 10'($urandom_range(0, VARS - 1)),
                              1'($urandom_range(0, 1)), $urandom));
        end else if (roll == 1) begin
          send_word(make_word(MODE_ADD_DEG, 10'($urandom_range(0, VARS - 1)),
                              1'($urandom_range(0, 1)), pick_amount()));
        end else begin
          send_word(make_word((roll < 8) ? MODE_LOAD : MODE_ADD,
                              pool[$urandom_range(0, pool_n - 1)],
                              1'($urandom_range(0, 1)), pick_amount()));
        end
      end
      n_pops = pool_n + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) n_pops = $urandom_range(0, pool_n);
      for (int u = 0; u < n_pops; u++) begin
        // The unused fields of an unload word carry random bits.
        send_word(make_word(MODE_UNLOAD, 10'($urandom_range(0, VARS - 1)),
                            1'($urandom_range(0, 1)), $urandom));
        if ($urandom_range(0, 9) == 0) begin
          send_word(make_word($urandom_range(0, 1) ? MODE_ADD : MODE_LOAD,
                              10'($urandom_range(0, VARS - 1)), 1'($urandom_range(0, 1)),
                              pick_amount()));
        end
      end
      if ($urandom_range(0, 7) == 0) drain();
    end

    // Wait for the last status word, then keep the clock running so that a stray
    // strobe would still be caught.
    drain();
    repeat (10) @(posedge clk);

    spare_hits = 0;
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) spare_hits += mode_hits[m];
    $display("Covered %0d loads, %0d adds, %0d degree sets, %0d degree adds, %0d unloads",
             mode_hits[MODE_LOAD], mode_hits[MODE_ADD], mode_hits[MODE_SET_DEG],
             mode_hits[MODE_ADD_DEG], mode_hits[MODE_UNLOAD]);
    $display("and %0d spare-mode words; %0d status words checked field by field.",
             spare_hits, compared);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== pb_constraint_accumulator_top.f =====
hdl/pbca_pkg.sv
hdl/pbca_ram.sv
hdl/pb_constraint_accumulator_top.sv
dv/pbca_status_checker.sv
dv/pb_constraint_accumulator_top_tb.sv
